@@ rtl/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the piezo pad peak trigger
// Field widths, register indexes and reset values, configuration bundle and
// the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int PAD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int CODE_W     = 8;
  localparam int NOTE_W     = 8;
  localparam int VEL_W      = 7;
  localparam int NOTE_MAP_W = 48;
  localparam int NOTE_MAP_PADS = NOTE_MAP_W / NOTE_W;

  // velocity scale: sample * 127 = (sample << 7) - sample
  localparam int VEL_SHIFT = 7;
  localparam int DIVD_W    = SAMPLE_W + VEL_SHIFT;
  localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

  localparam int PAD_COUNT_DEF = 6;
  localparam int CMD_DEPTH     = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_MAP   = 3'd5;

  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST  = 10'd20;
  localparam logic [SAMPLE_W-1:0]   FULL_SCALE_RST = 10'd120;
  localparam logic [DEB_W-1:0]      DEBOUNCE_RST   = 16'd50;
  localparam logic [CODE_W-1:0]     NOTE_ON_RST    = 8'd90;
  localparam logic [CODE_W-1:0]     OFF_CODE_RST   = 8'd80;
  localparam logic [NOTE_MAP_W-1:0] NOTE_MAP_RST   = 48'd54091408090659;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   threshold;
    logic [SAMPLE_W-1:0]   full_scale;
    logic [DEB_W-1:0]      debounce;
    logic [CODE_W-1:0]     note_on;
    logic [CODE_W-1:0]     off_code;
    logic [NOTE_MAP_W-1:0] note_map;
  } ppt_cfg_t;

  typedef enum logic {
    OP_TRACK,
    OP_RELEASE
  } ppt_op_e;

  typedef struct packed {
    ppt_op_e             op;
    logic [PAD_W-1:0]    pad;
    logic [SAMPLE_W-1:0] sample;
  } ppt_cmd_t;

endpackage

@@ rtl/ppt_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ppt_cmd_fifo: command queue between front end and back end
// Small register FIFO, first-word fall-through.
// ----------------------------------------------------------------------------
module ppt_cmd_fifo import ppt_pkg::*; #(
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ppt_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output ppt_cmd_t pop_data_o,
  output logic     empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppt_cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ppt_front.sv @@
// ----------------------------------------------------------------------------
// ppt_front: sample classifier
// Keeps per-pad arm flags and release times, decides arm / track / release
// for every sample and queues the work for the back end.
// ----------------------------------------------------------------------------
module ppt_front import ppt_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppt_cfg_t            cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PAD_W-1:0]    pad_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [TIME_W-1:0]   now_i,
  output logic                push_o,
  output ppt_cmd_t            push_data_o,
  input  logic                full_i
);

  localparam int PAD_IW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  logic                armed_q   [PAD_COUNT];
  logic [TIME_W-1:0]   release_q [PAD_COUNT];

  logic                accept, in_range, loud, armed, settled;
  logic [PAD_IW-1:0]   idx;
  logic [TIME_W-1:0]   elapsed;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign in_range   = ({{(32-PAD_W){1'b0}}, pad_i} < 32'(PAD_COUNT));
  assign idx        = PAD_IW'(pad_i);
  assign loud       = (sample_i >= cfg_i.threshold);
  assign armed      = in_range ? armed_q[idx] : 1'b0;
  assign elapsed    = now_i - (in_range ? release_q[idx] : '0);
  assign settled    = (elapsed >= {{(TIME_W-DEB_W){1'b0}}, cfg_i.debounce});

  always_comb begin
    push_o             = 1'b0;
    push_data_o.op     = OP_TRACK;
    push_data_o.pad    = pad_i;
    push_data_o.sample = sample_i;
    if (accept && in_range) begin
      if (!armed) begin
        push_o = loud && settled;
      end else if (loud) begin
        push_o = 1'b1;
      end else begin
        push_o         = 1'b1;
        push_data_o.op = OP_RELEASE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        armed_q[i]   <= 1'b0;
        release_q[i] <= '0;
      end
    end else if (accept && in_range) begin
      if (!armed) begin
        if (loud && settled) begin
          armed_q[idx] <= 1'b1;
        end
      end else if (!loud) begin
        armed_q[idx]   <= 1'b0;
        release_q[idx] <= now_i;
      end
    end
  end

endmodule

@@ rtl/ppt_back.sv @@
// ----------------------------------------------------------------------------
// ppt_back: velocity and message engine
// Radix-2 restoring divide for the velocity, per-pad peak hold, and the
// note-on / note-off pair into a registered output stage.
// ----------------------------------------------------------------------------
module ppt_back import ppt_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppt_cfg_t          cfg_i,
  input  logic              empty_i,
  input  ppt_cmd_t          pop_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic [NOTE_W-1:0] out_note_o,
  output logic [VEL_W-1:0]  out_vel_o,
  output logic [PAD_W-1:0]  out_pad_o,
  output logic              out_last_o
);

  localparam int PAD_IW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int CNT_W  = $clog2(DIVD_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPDATE,
    S_ON,
    S_OFF
  } state_e;

  state_e              state_q;
  ppt_cmd_t            cmd_q;
  logic [DIVD_W-1:0]   quot_q;
  logic [SAMPLE_W-1:0] rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [VEL_W-1:0]    peak_q [PAD_COUNT];

  logic                out_valid_q, out_last_q;
  logic [CODE_W-1:0]   out_code_q;
  logic [NOTE_W-1:0]   out_note_q;
  logic [VEL_W-1:0]    out_vel_q;
  logic [PAD_W-1:0]    out_pad_q;

  logic [PAD_IW-1:0]   idx;
  logic [SAMPLE_W-1:0] span;
  logic                span_bad;
  logic [DIVD_W-1:0]   dividend;
  logic [SAMPLE_W:0]   trial;
  logic                fits;
  logic [VEL_W-1:0]    vel, peak;
  logic [NOTE_W-1:0]   note;
  logic                out_free, out_load;

  assign idx      = PAD_IW'(cmd_q.pad);
  assign peak     = peak_q[idx];
  assign span     = cfg_i.full_scale - cfg_i.threshold;
  assign span_bad = (cfg_i.full_scale <= cfg_i.threshold);
  assign dividend = {pop_data_i.sample, {VEL_SHIFT{1'b0}}}
                  - {{VEL_SHIFT{1'b0}}, pop_data_i.sample};
  assign trial    = {rem_q, quot_q[DIVD_W-1]};
  assign fits     = (trial >= {1'b0, span});
  // quotient above the top velocity clamps
  assign vel      = (|quot_q[DIVD_W-1:VEL_W]) ? VEL_MAX : quot_q[VEL_W-1:0];
  assign note     = ({{(32-PAD_W){1'b0}}, cmd_q.pad} < 32'(NOTE_MAP_PADS))
                  ? NOTE_W'(cfg_i.note_map >> (NOTE_W * int'(cmd_q.pad)))
                  : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == S_ON) || (state_q == S_OFF)) && out_free;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_note_o  = out_note_q;
  assign out_vel_o   = out_vel_q;
  assign out_pad_o   = out_pad_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          cmd_q  <= pop_data_i;
          rem_q  <= '0;
          quot_q <= span_bad ? DIVD_W'(VEL_MAX) : dividend;
        end
      end
      S_DIV: begin
        quot_q <= {quot_q[DIVD_W-2:0], fits};
        rem_q  <= fits ? SAMPLE_W'(trial - {1'b0, span}) : trial[SAMPLE_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_note_q  <= '0;
      out_vel_q   <= '0;
      out_pad_q   <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        peak_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cnt_q <= '0;
            if (pop_data_i.op == OP_RELEASE) begin
              state_q <= S_ON;
            end else if (span_bad) begin
              state_q <= S_UPDATE;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIVD_W - 1)) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (vel > peak) begin
            peak_q[idx] <= vel;
          end
          state_q <= S_IDLE;
        end
        S_ON: begin
          if (out_free) begin
            out_code_q <= cfg_i.note_on;
            out_note_q <= note;
            out_vel_q  <= peak;
            out_pad_q  <= cmd_q.pad;
            out_last_q <= 1'b0;
            state_q    <= S_OFF;
          end
        end
        S_OFF: begin
          if (out_free) begin
            out_code_q  <= cfg_i.off_code;
            out_note_q  <= note;
            out_vel_q   <= '0;
            out_pad_q   <= cmd_q.pad;
            out_last_q  <= 1'b1;
            peak_q[idx] <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/piezo_pad_peak_trigger.sv @@
// ----------------------------------------------------------------------------
// piezo_pad_peak_trigger: drum pad hit detector with peak velocity
// A sample is taken while the command queue has room; a loud sample then
// holds the back end through the 17-step divide and the peak update, a release
// through the note-on and note-off states. A release runs through the queue, the
// back-end states and the output register; async reset, all pads idle.
// ----------------------------------------------------------------------------
//
// Structure
//   ppt_front    - per-pad arm flag and release time. Applies the threshold
//                  and the debounce window (wrapping 32-bit difference) and
//                  emits one of two requests: track a loud sample, or
//                  release the pad. Samples for pads beyond PAD_COUNT, quiet
//                  idle samples and debounced hits produce no request.
//   ppt_cmd_fifo - CMD_DEPTH-entry queue, lets the front keep taking
//                  samples while the back end divides.
//   ppt_back     - velocity = floor(sample*127/span) by a restoring radix-2
//                  divider, one quotient bit a cycle over 17 bits, clamped
//                  to 127; saturates at once when full scale <= threshold.
//                  Holds the per-pad peak and sends the note-on / note-off
//                  pair through a registered output stage.
//
// Throughput is set by the back end, which takes a request only when idle: a
// loud sample holds it through the divide, a release through both messages and
// any output stall. Configuration reset values are the documented defaults.

module piezo_pad_peak_trigger import ppt_pkg::*; #(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream: [2:0] pad_index, [12:3] sample_level, [44:13] now_ms
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,
  // master stream: [7:0] message_code, [15:8] note_number,
  //                [22:16] velocity, [25:23] source_pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,
  output logic                  m_axis_tlast,   // last_of_hit
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ppt_cfg_t cfg_q;

  // register file; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.full_scale <= FULL_SCALE_RST;
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.note_on    <= NOTE_ON_RST;
      cfg_q.off_code   <= OFF_CODE_RST;
      cfg_q.note_map   <= NOTE_MAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i[SAMPLE_W-1:0];
        REG_FULL_SCALE: cfg_q.full_scale <= cfg_data_i[SAMPLE_W-1:0];
        REG_DEBOUNCE:   cfg_q.debounce   <= cfg_data_i[DEB_W-1:0];
        REG_NOTE_ON:    cfg_q.note_on    <= cfg_data_i[CODE_W-1:0];
        REG_OFF_CODE:   cfg_q.off_code   <= cfg_data_i[CODE_W-1:0];
        REG_NOTE_MAP:   cfg_q.note_map   <= cfg_data_i[NOTE_MAP_W-1:0];
        default: ;
      endcase
    end
  end

  logic     push, full, pop, empty;
  ppt_cmd_t push_data, pop_data;

  ppt_front #(
    .PAD_COUNT (PAD_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pad_i       (s_axis_tdata[2:0]),
    .sample_i    (s_axis_tdata[12:3]),
    .now_i       (s_axis_tdata[44:13]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ppt_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  logic [CODE_W-1:0] out_code;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0]  out_vel;
  logic [PAD_W-1:0]  out_pad;

  ppt_back #(
    .PAD_COUNT (PAD_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (out_code),
    .out_note_o  (out_note),
    .out_vel_o   (out_vel),
    .out_pad_o   (out_pad),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_pad, out_vel, out_note, out_code};

endmodule

@@ tb/sv/piezo_pad_peak_trigger_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piezo_pad_peak_trigger_check: note message predictor and scoreboard
// Watches the sample, message and register ports, keeps its own per-pad arm,
// peak and release state, and checks every note message in order.
// ----------------------------------------------------------------------------
module piezo_pad_peak_trigger_check import ppt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [47:0]           s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [31:0]           m_tdata_i,
  input  logic                  m_tlast_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    samples_o,
  output int                    hits_o,
  output int                    debounced_o,
  output int                    saturated_o,
  output int                    ignored_o,
  output int                    messages_o
);

  localparam int PADS = PAD_COUNT_DEF;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [PAD_W-1:0]  pad;
    logic              last;
  } note_msg_t;

  note_msg_t pending_notes[$];

  logic [SAMPLE_W-1:0]   threshold;
  logic [SAMPLE_W-1:0]   full_scale;
  logic [DEB_W-1:0]      debounce;
  logic [CODE_W-1:0]     note_on;
  logic [CODE_W-1:0]     off_code;
  logic [NOTE_MAP_W-1:0] note_map;

  logic              armed       [PADS];
  logic [VEL_W-1:0]  peak        [PADS];
  logic [TIME_W-1:0] released_at [PADS];

  function automatic logic [VEL_W-1:0] scaled_velocity(logic [SAMPLE_W-1:0] lvl);
    int unsigned q;
    if (full_scale <= threshold) return VEL_MAX;
    q = (int'(lvl) * 127) / int'(full_scale - threshold);
    return (q > 127) ? VEL_MAX : q[VEL_W-1:0];
  endfunction

  task automatic track_peak(logic [PAD_W-1:0] pad, logic [SAMPLE_W-1:0] lvl);
    logic [VEL_W-1:0] vel;
    vel = scaled_velocity(lvl);
    if (vel == VEL_MAX) saturated_o++;
    if (vel > peak[pad]) peak[pad] = vel;
  endtask

  task automatic predict_sample(logic [PAD_W-1:0] pad, logic [SAMPLE_W-1:0] lvl,
                                logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0]     since;
    logic [NOTE_MAP_W-1:0] shifted;
    note_msg_t             msg;
    samples_o++;
    if (pad >= PADS) begin
      ignored_o++;
      return;
    end
    if (!armed[pad]) begin
      if (lvl >= threshold) begin
        since = stamp - released_at[pad];
        if (since >= TIME_W'(debounce)) begin
          armed[pad] = 1'b1;
          track_peak(pad, lvl);
        end else begin
          debounced_o++;
        end
      end
      return;
    end
    if (lvl >= threshold) begin
      track_peak(pad, lvl);
      return;
    end
    // release: note-on with the peak, then note-off
    shifted = note_map >> (NOTE_W * pad);
    msg = '{code: note_on, note: shifted[NOTE_W-1:0], vel: peak[pad], pad: pad, last: 1'b0};
    pending_notes.push_back(msg);
    msg.code = off_code;
    msg.vel  = '0;
    msg.last = 1'b1;
    pending_notes.push_back(msg);
    peak[pad]        = '0;
    armed[pad]       = 1'b0;
    released_at[pad] = stamp;
    hits_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    note_msg_t got, want;
    if (!rst_ni) begin
      pending_notes.delete();
      threshold  = THRESHOLD_RST;
      full_scale = FULL_SCALE_RST;
      debounce   = DEBOUNCE_RST;
      note_on    = NOTE_ON_RST;
      off_code   = OFF_CODE_RST;
      note_map   = NOTE_MAP_RST;
      for (int p = 0; p < PADS; p++) begin
        armed[p]       = 1'b0;
        peak[p]        = '0;
        released_at[p] = '0;
      end
      fail_count_o = 0;
      pending_o    = 0;
      samples_o    = 0;
      hits_o       = 0;
      debounced_o  = 0;
      saturated_o  = 0;
      ignored_o    = 0;
      messages_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_THRESHOLD:  threshold  = cfg_data_i[SAMPLE_W-1:0];
          REG_FULL_SCALE: full_scale = cfg_data_i[SAMPLE_W-1:0];
          REG_DEBOUNCE:   debounce   = cfg_data_i[DEB_W-1:0];
          REG_NOTE_ON:    note_on    = cfg_data_i[CODE_W-1:0];
          REG_OFF_CODE:   off_code   = cfg_data_i[CODE_W-1:0];
          REG_NOTE_MAP:   note_map   = cfg_data_i[NOTE_MAP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        messages_o++;
        got = '{code: m_tdata_i[7:0], note: m_tdata_i[15:8], vel: m_tdata_i[22:16],
                pad: m_tdata_i[25:23], last: m_tlast_i};
        if (pending_notes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 40)
            $display("%0t: unexpected message code %0d note %0d vel %0d pad %0d last %0d",
                     $realtime, got.code, got.note, got.vel, got.pad, got.last);
        end else begin
          want = pending_notes.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 40)
              $display({"%0t: message mismatch, expected code %0d note %0d vel %0d ",
                        "pad %0d last %0d, got code %0d note %0d vel %0d pad %0d last %0d"},
                       $realtime, want.code, want.note, want.vel, want.pad, want.last,
                       got.code, got.note, got.vel, got.pad, got.last);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        predict_sample(s_tdata_i[2:0], s_tdata_i[12:3], s_tdata_i[44:13]);
      pending_o = pending_notes.size();
    end
  end

endmodule

@@ tb/sv/piezo_pad_peak_trigger_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piezo_pad_peak_trigger_test: regression bench for the pad peak trigger
// Directed hits, debounce and out-of-range samples, then randomised hit
// sequences across six register settings, with bursty requests, a stalling
// message sink and one long back-pressure episode. Checking is done by the
// scoreboard module alongside the DUT.
// ----------------------------------------------------------------------------
module piezo_pad_peak_trigger_test;
  import ppt_pkg::*;

  localparam int DRAIN_CYCLES = 160;  // deepest loud backlog plus output stage
  localparam int LONG_HOLD    = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count, pending, samples, hits, debounced, saturated, ignored, messages;

  // stimulus-side copy of the threshold, only to shape loud / quiet levels
  logic [SAMPLE_W-1:0] thr_now = THRESHOLD_RST;
  logic [TIME_W-1:0]   clock_ms = '0;
  int                  burst_left = 0;
  bit                  long_hold_done = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  piezo_pad_peak_trigger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  piezo_pad_peak_trigger_check scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .samples_o    (samples),
    .hits_o       (hits),
    .debounced_o  (debounced),
    .saturated_o  (saturated),
    .ignored_o    (ignored),
    .messages_o   (messages)
  );

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("piezo_pad_peak_trigger regression: fail");
    $finish;
  end

  // Message sink: ready pattern changes mode every so often (always ready,
  // coin toss, mostly stalled). Once a few dozen messages are through it
  // holds off for a long stretch, starting while requests are on offer, so
  // the command queue backs up into the sample port.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && messages >= 40 && s_axis_tvalid) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 150);
      end
      left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // One sample request; bursts of random length separated by random gaps.
  task automatic offer(logic [PAD_W-1:0] pad, logic [SAMPLE_W-1:0] lvl,
                       logic [TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, stamp, lvl, pad};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every note message is out, then give the
  // divider time to finish samples that raise no message.
  task automatic quiesce(int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [SAMPLE_W-1:0] thr, logic [SAMPLE_W-1:0] fs,
                          logic [DEB_W-1:0] deb, logic [CODE_W-1:0] on_code,
                          logic [CODE_W-1:0] off_code, logic [NOTE_MAP_W-1:0] map);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(REG_NOTE_ON, CFG_DATA_W'(on_code));
    write_reg(REG_OFF_CODE, CFG_DATA_W'(off_code));
    write_reg(REG_NOTE_MAP, map);
    cfg_we_i <= 1'b0;
    thr_now = thr;
  endtask

  function automatic logic [SAMPLE_W-1:0] loud_level();
    case ($urandom_range(0, 7))
      0:       return thr_now;
      1:       return 10'd1023;
      default: return SAMPLE_W'($urandom_range(thr_now, 1023));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] quiet_level();
    if (thr_now == 0) return loud_level();  // nothing is below a zero threshold
    return ($urandom_range(0, 3) == 0) ? 10'd0
                                       : SAMPLE_W'($urandom_range(0, thr_now - 1));
  endfunction

  // advance the millisecond clock; the odd jump anywhere exercises wrap
  task automatic send(logic [PAD_W-1:0] pad, logic [SAMPLE_W-1:0] lvl, int step_max);
    if ($urandom_range(0, 63) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, step_max);
    offer(pad, lvl, clock_ms);
  endtask

  // Mostly whole hits on one pad (loud samples then a quiet one); the rest
  // is noise on any pad index including the two unused ones.
  task automatic random_phase(int count, int step_max);
    int  done, n;
    bit  paused;
    logic [PAD_W-1:0] pad;
    done   = 0;
    paused = 1'b0;
    while (done < count) begin
      if (!paused && done >= count / 2) begin
        quiesce(0);
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        pad = PAD_W'($urandom_range(0, 7));
        send(pad, SAMPLE_W'($urandom_range(0, 1023)), step_max);
        if (pad < PAD_COUNT_DEF) done++;
      end else begin
        pad = PAD_W'($urandom_range(0, PAD_COUNT_DEF - 1));
        n   = $urandom_range(1, 4);
        repeat (n) send(pad, loud_level(), step_max);
        send(pad, quiet_level(), step_max);
        done += n + 1;
      end
    end
    quiesce(DRAIN_CYCLES);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed, reset register values (threshold 20, span 100, 50 ms)
    offer(3'd0, 10'd500, 32'd10);          // inside debounce window after reset
    offer(3'd0, 10'd5, 32'd20);            // quiet idle pad
    offer(3'd6, 10'd1023, 32'd100);        // pads beyond the last are ignored
    offer(3'd7, 10'd0, 32'd100);
    offer(3'd0, 10'd20, 32'd100);          // exactly threshold arms
    offer(3'd0, 10'd1023, 32'd101);        // velocity clamps at top
    offer(3'd0, 10'd19, 32'd102);          // release
    offer(3'd5, 10'd60, 32'd200);
    offer(3'd5, 10'd0, 32'd201);
    offer(3'd0, 10'd300, 32'd130);         // still inside window
    offer(3'd0, 10'd300, 32'd152);         // window exactly elapsed
    offer(3'd0, 10'd0, 32'd153);
    offer(3'd1, 10'd1023, 32'hFFFF_FFF0);  // timestamp near wrap
    offer(3'd1, 10'd0, 32'hFFFF_FFF8);
    offer(3'd1, 10'd500, 32'h0000_0010);   // wrapped difference below window
    offer(3'd1, 10'd500, 32'h0000_002A);   // wrapped difference reaches window
    offer(3'd1, 10'd3, 32'h0000_002B);
    offer(3'd2, 10'd80, 32'd400);          // peak held over a lower sample
    offer(3'd2, 10'd30, 32'd401);
    offer(3'd2, 10'd0, 32'd402);
    offer(3'd3, 10'd21, 32'd400);
    offer(3'd3, 10'd1, 32'd401);
    offer(3'd4, 10'd119, 32'd400);
    offer(3'd4, 10'd19, 32'd401);
    clock_ms = 32'd1000;
    quiesce(DRAIN_CYCLES);

    // ---- random, across register settings
    // zero threshold: nothing ever releases; widest span, no debounce
    set_regs(10'd0, 10'd1023, 16'd0, 8'd0, 8'd255, 48'd0);
    random_phase(100, 20);
    // top threshold, equal full scale, longest debounce, all-ones note map
    set_regs(10'd1023, 10'd1023, 16'hFFFF, 8'd255, 8'd0, 48'hFFFF_FFFF_FFFF);
    random_phase(180, 40000);
    // full scale below threshold: every velocity saturates
    set_regs(10'd300, 10'd200, 16'd5, 8'h90, 8'h80, 48'h2A2B_2C2D_2E2F);
    random_phase(180, 8);
    // span of one
    set_regs(10'd1, 10'd2, 16'd0, 8'h99, 8'h89, 48'h0102_0304_0506);
    random_phase(180, 4);
    // wide span, graded velocities
    set_regs(10'd100, 10'd1023, 16'd20, 8'h91, 8'h81, NOTE_MAP_RST);
    random_phase(180, 15);
    // anything goes
    set_regs(SAMPLE_W'($urandom_range(0, 1023)), SAMPLE_W'($urandom_range(0, 1023)),
             DEB_W'($urandom_range(0, 200)), CODE_W'($urandom_range(0, 255)),
             CODE_W'($urandom_range(0, 255)), NOTE_MAP_W'({$urandom(), $urandom()}));
    random_phase(180, 60);

    $display("covered %0d samples over six register settings: %0d hits, %0d messages,",
             samples, hits, messages);
    $display("  %0d debounced arms, %0d top velocities, %0d unused-pad samples",
             debounced, saturated, ignored);
    if (fail_count == 0 && pending == 0) begin
      $display("piezo_pad_peak_trigger regression: pass");
    end else begin
      $display("piezo_pad_peak_trigger regression: fail");
    end
    $finish;
  end

endmodule
